// File: rtl/dhcp_lt_pkg.sv
// ----------------------------------------------------------------------------
// dhcp_lt_pkg
// shared types and constants of the dhcp lease table: item structs, slot
// entry layout, mode and register codes, reset values and controller states
// ----------------------------------------------------------------------------
package dhcp_lt_pkg;

   localparam int DEF_MAX_SLOTS     = 128;
   localparam int DEF_MAX_POOL_SCAN = 256;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [1:0] MODE_ALLOC       = 2'd0;
   localparam logic [1:0] MODE_ADD         = 2'd1;
   localparam logic [1:0] MODE_LOOKUP_MAC  = 2'd2;
   localparam logic [1:0] MODE_LOOKUP_ADDR = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_START   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_END     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERVER_ADDR  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOTS_IN_USE = 2'd3;

   localparam logic [31:0] POOL_START_RST   = 32'hC0A8_000C;
   localparam logic [31:0] POOL_END_RST     = 32'hC0A8_0064;
   localparam logic [31:0] SERVER_ADDR_RST  = 32'hC0A8_0001;
   localparam logic [7:0]  SLOTS_IN_USE_RST = 8'd88;

   localparam logic [7:0]  LOW_BYTE_NET   = 8'h00;
   localparam logic [7:0]  LOW_BYTE_BCAST = 8'hFF;
   localparam logic [31:0] LEASE_FOREVER  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] now;
      logic [47:0] client_mac;
      logic [31:0] address;
      logic [31:0] lease_seconds;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [6:0]  slot;
      logic [31:0] result_address;
      logic [31:0] expiry;
      logic        is_expired;
   } rsp_type;

   typedef struct packed {
      logic [47:0] mac;
      logic [31:0] address;
      logic [31:0] expiry;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC_TEST,
      ST_SCAN
   } state_type;

endpackage

// File: rtl/dhcp_lease_table_top.sv
// ----------------------------------------------------------------------------
// dhcp_lease_table_top
// lease table of mac, address and expiry per slot, held in one memory and
// scanned one slot per cycle for allocate, add lease and the two lookups
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on rsp_data for exactly one cycle with rsp_valid high and cannot be
// held off. After reset the table memory is zeroed by a pass over all MAX_SLOTS
// slots, during which busy stays high (csr writes are taken throughout).
// The slot memory has one read port, so every scan visits one slot per
// cycle: with n = min(slots_in_use, MAX_SLOTS), add lease and both lookups
// read at most n slots (a lookup hit ends early), and allocate reads up to
// n slots for each pool address it tests, over at most MAX_POOL_SCAN
// addresses; a skipped address is passed over without a scan.
module dhcp_lease_table_top
   import dhcp_lt_pkg::*;
#(
   parameter int MAX_SLOTS     = DEF_MAX_SLOTS,
   parameter int MAX_POOL_SCAN = DEF_MAX_POOL_SCAN
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
   localparam int SCAN_W = $clog2(MAX_POOL_SCAN);

   function automatic logic [6:0] slot_field(input logic [SLOT_W-1:0] idx);
      logic [SLOT_W+6:0] ext;
      ext = {7'b0, idx};
      return ext[6:0];
   endfunction

   // configuration
   logic [31:0] pool_start_ff;
   logic [31:0] pool_end_ff;
   logic [31:0] server_addr_ff;
   logic [7:0]  slots_ff;

   // control and datapath registers
   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  issue_idx_ff, issue_idx_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] pend_idx_ff, pend_idx_in;
   entry_type         rd_data_ff;
   logic [31:0]       cand_ff, cand_in;
   logic [SCAN_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [31:0]       best_time_ff, best_time_in;
   logic [SLOT_W-1:0] best_idx_ff, best_idx_in;
   logic              best_found_ff, best_found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // memory ports
   entry_type         mem [MAX_SLOTS];
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   entry_type         mem_wdata;
   logic              mem_re;

   // decisions
   logic [CNT_W-1:0] n_used;
   logic             issue_more;
   logic             scan_end;
   logic             hit;
   logic             clear_match;
   logic             alloc_skip;
   logic             alloc_last;
   logic             clear_done;
   logic [31:0]      eff_expiry;
   logic [31:0]      new_expiry;

   assign n_used = (CMP_W'(slots_ff) > CMP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                          : CNT_W'(slots_ff);
   assign issue_more = issue_idx_ff < n_used;
   assign scan_end   = !pend_ff && !issue_more;
   assign clear_done = issue_idx_ff == CNT_W'(MAX_SLOTS - 1);

   assign clear_match = pend_ff && ((rd_data_ff.mac == req_ff.client_mac) ||
                        ((req_ff.address != 32'd0) &&
                         (rd_data_ff.address == req_ff.address)));
   assign eff_expiry = clear_match ? 32'd0 : rd_data_ff.expiry;

   always_comb begin
      unique case (req_ff.mode)
         MODE_ALLOC:       hit = pend_ff && (rd_data_ff.address == cand_ff);
         MODE_LOOKUP_MAC:  hit = pend_ff && (rd_data_ff.mac == req_ff.client_mac);
         MODE_LOOKUP_ADDR: hit = pend_ff && (rd_data_ff.address == req_ff.address);
         default:          hit = 1'b0;
      endcase
   end

   assign alloc_skip = (cand_ff[7:0] == LOW_BYTE_NET) ||
                       (cand_ff[7:0] == LOW_BYTE_BCAST) ||
                       (cand_ff == server_addr_ff);
   assign alloc_last = (cand_ff == pool_end_ff) ||
                       (scan_cnt_ff == SCAN_W'(MAX_POOL_SCAN - 1));

   assign new_expiry = (req_ff.lease_seconds == LEASE_FOREVER) ? LEASE_FOREVER
                       : req_ff.now + req_ff.lease_seconds;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = (req_data.mode == MODE_ALLOC) ? ST_ALLOC_TEST : ST_SCAN;
         end
         ST_ALLOC_TEST: begin
            if (!alloc_skip) state_in = ST_SCAN;
            else if (alloc_last) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = ((req_ff.mode == MODE_ALLOC) && !alloc_last) ? ST_ALLOC_TEST
                                                                       : ST_IDLE;
            end else if (scan_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in        = req_ff;
      issue_idx_in  = issue_idx_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      cand_in       = cand_ff;
      scan_cnt_in   = scan_cnt_ff;
      best_time_in  = best_time_ff;
      best_idx_in   = best_idx_ff;
      best_found_in = best_found_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = issue_idx_ff[SLOT_W-1:0];
      mem_wdata     = '0;
      mem_re        = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we       = 1'b1;
            issue_idx_in = issue_idx_ff + CNT_W'(1);
         end
         ST_IDLE: begin
            if (start) begin
               req_in        = req_data;
               issue_idx_in  = '0;
               cand_in       = pool_start_ff;
               scan_cnt_in   = '0;
               best_time_in  = req_data.now;
               best_found_in = 1'b0;
            end
         end
         ST_ALLOC_TEST: begin
            issue_idx_in = '0;
            if (alloc_skip) begin
               if (alloc_last) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end else begin
                  cand_in     = cand_ff + 32'd1;
                  scan_cnt_in = scan_cnt_ff + SCAN_W'(1);
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               if (req_ff.mode == MODE_ALLOC) begin
                  if (alloc_last) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end else begin
                     cand_in     = cand_ff + 32'd1;
                     scan_cnt_in = scan_cnt_ff + SCAN_W'(1);
                  end
               end else begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.found          = 1'b1;
                  rsp_in.slot           = slot_field(pend_idx_ff);
                  rsp_in.result_address = rd_data_ff.address;
                  rsp_in.expiry         = rd_data_ff.expiry;
                  rsp_in.is_expired     = rd_data_ff.expiry < req_ff.now;
               end
            end else begin
               if (issue_more) begin
                  mem_re       = 1'b1;
                  pend_in      = 1'b1;
                  pend_idx_in  = issue_idx_ff[SLOT_W-1:0];
                  issue_idx_in = issue_idx_ff + CNT_W'(1);
               end
               if ((req_ff.mode == MODE_ADD) && pend_ff) begin
                  if (clear_match) begin
                     mem_we    = 1'b1;
                     mem_waddr = pend_idx_ff;
                  end
                  if (eff_expiry < best_time_ff) begin
                     best_time_in  = eff_expiry;
                     best_idx_in   = pend_idx_ff;
                     best_found_in = 1'b1;
                  end
               end
               if (scan_end) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  if (req_ff.mode == MODE_ALLOC) begin
                     rsp_in.found          = 1'b1;
                     rsp_in.result_address = cand_ff;
                  end else if ((req_ff.mode == MODE_ADD) && best_found_ff) begin
                     mem_we                = 1'b1;
                     mem_waddr             = best_idx_ff;
                     mem_wdata.mac         = req_ff.client_mac;
                     mem_wdata.address     = req_ff.address;
                     mem_wdata.expiry      = new_expiry;
                     rsp_in.found          = 1'b1;
                     rsp_in.slot           = slot_field(best_idx_ff);
                     rsp_in.result_address = req_ff.address;
                     rsp_in.expiry         = new_expiry;
                     rsp_in.is_expired     = new_expiry < req_ff.now;
                  end
               end
            end
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[issue_idx_ff[SLOT_W-1:0]];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         issue_idx_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_idx_ff <= issue_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      pend_idx_ff   <= pend_idx_in;
      cand_ff       <= cand_in;
      scan_cnt_ff   <= scan_cnt_in;
      best_time_ff  <= best_time_in;
      best_idx_ff   <= best_idx_in;
      best_found_ff <= best_found_in;
      rsp_ff        <= rsp_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_start_ff  <= POOL_START_RST;
         pool_end_ff    <= POOL_END_RST;
         server_addr_ff <= SERVER_ADDR_RST;
         slots_ff       <= SLOTS_IN_USE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_POOL_START:   pool_start_ff  <= csr_data;
            CSR_POOL_END:     pool_end_ff    <= csr_data;
            CSR_SERVER_ADDR:  server_addr_ff <= csr_data;
            CSR_SLOTS_IN_USE: slots_ff       <= csr_data[7:0];
            default: begin
               slots_ff <= slots_ff;
            end
         endcase
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

// File: rtl/dhcp_lt_checker.sv
// ----------------------------------------------------------------------------
// dhcp_lt_checker
// port-level checks of the lease table: result timing against busy and the
// zero fields of a miss
// ----------------------------------------------------------------------------
module dhcp_lt_checker
   import dhcp_lt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // an accepted item keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after item accepted");

   // a result closes an item, so the block is free while it is shown
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result shown while busy or without work");

   // one item gives one result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result repeated");

   // a miss carries all zero fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |->
         ((rsp_data.slot == 7'd0) && (rsp_data.result_address == 32'd0) &&
          (rsp_data.expiry == 32'd0) && !rsp_data.is_expired))
      else $error("miss with nonzero fields");

endmodule

bind dhcp_lease_table_top dhcp_lt_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
